@@ hdl/bc_pkg.sv @@
package bc_pkg;

   localparam int N_LIMIT_DEFAULT = 60;

   localparam int FIELD_W = 6;
   localparam int COEF_W  = 57;
   localparam int PROD_W  = 64;
   localparam int IDX_W   = 5;
   localparam int PC_W    = 3;
   localparam int CNT_W   = 6;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_SETUP,
      OP_MUL,
      OP_DIV,
      OP_NEXT,
      OP_EMIT,
      OP_EMIT_ZERO
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_START,
      COND_BAD,
      COND_LOOP_END,
      COND_DIV_BUSY
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic bad;
      logic loop_end;
      logic div_busy;
   } status_type;

   localparam logic [PC_W-1:0] STEP_IDLE  = 3'd0;
   localparam logic [PC_W-1:0] STEP_SETUP = 3'd1;
   localparam logic [PC_W-1:0] STEP_TEST  = 3'd2;
   localparam logic [PC_W-1:0] STEP_MUL   = 3'd3;
   localparam logic [PC_W-1:0] STEP_DIV   = 3'd4;
   localparam logic [PC_W-1:0] STEP_NEXT  = 3'd5;
   localparam logic [PC_W-1:0] STEP_DONE  = 3'd6;
   localparam logic [PC_W-1:0] STEP_ZERO  = 3'd7;

   // The program: a conditional jump is taken when its condition holds,
   // otherwise the step counter moves on by one.
   function automatic ctrl_word_type microcode(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      begin
         unique case (pc)
            STEP_IDLE:  w = '{op: OP_LOAD,      cond: COND_NO_START, target: STEP_IDLE};
            STEP_SETUP: w = '{op: OP_SETUP,     cond: COND_BAD,      target: STEP_ZERO};
            STEP_TEST:  w = '{op: OP_NONE,      cond: COND_LOOP_END, target: STEP_DONE};
            STEP_MUL:   w = '{op: OP_MUL,       cond: COND_NEVER,    target: STEP_IDLE};
            STEP_DIV:   w = '{op: OP_DIV,       cond: COND_DIV_BUSY, target: STEP_DIV};
            STEP_NEXT:  w = '{op: OP_NEXT,      cond: COND_ALWAYS,   target: STEP_TEST};
            STEP_DONE:  w = '{op: OP_EMIT,      cond: COND_ALWAYS,   target: STEP_IDLE};
            STEP_ZERO:  w = '{op: OP_EMIT_ZERO, cond: COND_ALWAYS,   target: STEP_IDLE};
            default:    w = '{op: OP_NONE,      cond: COND_ALWAYS,   target: STEP_IDLE};
         endcase
         return w;
      end
   endfunction

endpackage

@@ hdl/bc_datapath.sv @@
module bc_datapath #(
   parameter int N_LIMIT = bc_pkg::N_LIMIT_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bc_pkg::ctrl_word_type      ctrl,
   input  logic [bc_pkg::FIELD_W-1:0] req_n,
   input  logic [bc_pkg::FIELD_W-1:0] req_k,
   output bc_pkg::status_type         status,
   output logic                       rsp_valid,
   output logic [bc_pkg::COEF_W-1:0]  rsp_coefficient
);

   localparam logic [bc_pkg::FIELD_W-1:0] N_MAX = bc_pkg::FIELD_W'(N_LIMIT);

   logic [bc_pkg::FIELD_W-1:0] n_ff, n_in;
   logic [bc_pkg::FIELD_W-1:0] k_ff, k_in;
   logic [bc_pkg::IDX_W-1:0]   kk_ff, kk_in;
   logic [bc_pkg::IDX_W-1:0]   i_ff, i_in;
   logic [bc_pkg::COEF_W-1:0]  acc_ff, acc_in;
   logic [bc_pkg::PROD_W-1:0]  div_ff, div_in;
   logic [bc_pkg::IDX_W-1:0]   rem_ff, rem_in;
   logic [bc_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [bc_pkg::COEF_W-1:0]  coef_ff, coef_in;

   logic [bc_pkg::FIELD_W-1:0] n_minus_k;
   logic [bc_pkg::FIELD_W-1:0] factor;
   logic [bc_pkg::FIELD_W:0]   trial;
   logic                       fits;

   assign n_minus_k = n_ff - k_ff;
   assign factor    = n_ff - bc_pkg::FIELD_W'(kk_ff) + bc_pkg::FIELD_W'(i_ff);

   // One restoring division step: the next dividend bit joins the remainder.
   assign trial = {1'b0, rem_ff, div_ff[bc_pkg::PROD_W-1]};
   assign fits  = trial >= (bc_pkg::FIELD_W+1)'(i_ff);

   assign status.bad      = (n_ff > N_MAX) || (k_ff > n_ff);
   assign status.loop_end = i_ff > kk_ff;
   assign status.div_busy = cnt_ff != '0;

   always_comb begin
      n_in         = n_ff;
      k_in         = k_ff;
      kk_in        = kk_ff;
      i_in         = i_ff;
      acc_in       = acc_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      coef_in      = coef_ff;
      unique case (ctrl.op)
         bc_pkg::OP_NONE: begin
         end
         bc_pkg::OP_LOAD: begin
            n_in = req_n;
            k_in = req_k;
         end
         bc_pkg::OP_SETUP: begin
            kk_in  = (k_ff > n_minus_k) ? bc_pkg::IDX_W'(n_minus_k) : bc_pkg::IDX_W'(k_ff);
            i_in   = bc_pkg::IDX_W'(1);
            acc_in = bc_pkg::COEF_W'(1);
         end
         bc_pkg::OP_MUL: begin
            div_in = bc_pkg::PROD_W'(acc_ff) * bc_pkg::PROD_W'(factor);
            rem_in = '0;
            cnt_in = '1;
         end
         bc_pkg::OP_DIV: begin
            if (fits) begin
               rem_in = bc_pkg::IDX_W'(trial - (bc_pkg::FIELD_W+1)'(i_ff));
            end else begin
               rem_in = bc_pkg::IDX_W'(trial);
            end
            div_in = {div_ff[bc_pkg::PROD_W-2:0], fits};
            // The last step leaves the counter at zero.
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - bc_pkg::CNT_W'(1);
            end
         end
         bc_pkg::OP_NEXT: begin
            acc_in = div_ff[bc_pkg::COEF_W-1:0];
            i_in   = i_ff + bc_pkg::IDX_W'(1);
         end
         bc_pkg::OP_EMIT: begin
            rsp_valid_in = 1'b1;
            coef_in      = acc_ff;
         end
         bc_pkg::OP_EMIT_ZERO: begin
            rsp_valid_in = 1'b1;
            coef_in      = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      k_ff    <= k_in;
      kk_ff   <= kk_in;
      i_ff    <= i_in;
      acc_ff  <= acc_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      coef_ff <= coef_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coefficient = coef_ff;

endmodule

@@ hdl/binomial_coefficient.sv @@
// Binomial coefficient C(n, k) by the multiplicative rule.
// Input: drive req_n and req_k and raise start; the item is taken at a rising
// edge where start is high and busy is low. busy stays high until the result
// has been issued, and the inputs need only be valid at that accepting edge.
// Output: rsp_valid is high for exactly one cycle with rsp_coefficient; the
// receiver must take it then, as there is no back-pressure.
// k above n, or n above N_LIMIT, gives a zero result.
// Steps: min(k, n-k) passes, each of one loop test, one multiply step,
// bit-serial division steps over the 64-bit product and one update, with
// set-up before them and a final test and output after. Rejected items go
// from set-up straight to the zero result. busy falls in the cycle of the
// result, so the next item can be taken at the edge that takes the result.
// One item is worked at a time; the bit-serial divider is the longest part of each pass.
// A microcoded sequencer steps through a small constant program that drives
// the arithmetic datapath.
// Reset returns the step counter to idle and drops any item in progress;
// no result is issued for it.
module binomial_coefficient #(
   parameter int N_LIMIT = bc_pkg::N_LIMIT_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [bc_pkg::FIELD_W-1:0] req_n,
   input  logic [bc_pkg::FIELD_W-1:0] req_k,
   output logic                       rsp_valid,
   output logic [bc_pkg::COEF_W-1:0]  rsp_coefficient
);

   logic [bc_pkg::PC_W-1:0] pc_ff, pc_in;
   bc_pkg::ctrl_word_type   ctrl;
   bc_pkg::status_type      status;
   logic                    jump;

   assign ctrl = bc_pkg::microcode(pc_ff);
   assign busy = pc_ff != bc_pkg::STEP_IDLE;

   always_comb begin
      unique case (ctrl.cond)
         bc_pkg::COND_NEVER:    jump = 1'b0;
         bc_pkg::COND_ALWAYS:   jump = 1'b1;
         bc_pkg::COND_NO_START: jump = !start;
         bc_pkg::COND_BAD:      jump = status.bad;
         bc_pkg::COND_LOOP_END: jump = status.loop_end;
         bc_pkg::COND_DIV_BUSY: jump = status.div_busy;
         default:               jump = 1'b1;
      endcase
   end

   always_comb begin
      if (jump) begin
         pc_in = ctrl.target;
      end else begin
         pc_in = pc_ff + bc_pkg::PC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= bc_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   bc_datapath #(
      .N_LIMIT(N_LIMIT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .req_n          (req_n),
      .req_k          (req_k),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_coefficient(rsp_coefficient)
   );

`ifndef SYNTHESIS
   // An accepted item keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not make the block busy");

   // A result only ever follows a cycle in which an item was being worked.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result issued without an item in progress");

   // Each item yields a single one-cycle strobe.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   // The divider only runs in its own step of the program.
   a_div_in_step: assert property (@(posedge clock) disable iff (reset)
      status.div_busy |-> pc_ff == bc_pkg::STEP_DIV)
      else $error("division counter running outside the division step");
`endif

endmodule
